// ===== rtl/tjf_pkg.sv =====
// Shared types, character codes and byte classifiers for the token junk filter.
package tjf_pkg;

    // Per-token flags handed from the front end to the decision stage
    typedef struct packed {
        logic code;      // rule set for source code
        logic hex;       // every byte a hex digit
        logic uuid;      // still matches the UUID layout
        logic caps;      // only A-Z, 0-9, '_'
        logic bad;       // saw '=', "://", '/' or '\'
        logic pfx_hex;   // "0x" / "0X" prefix
        logic end_eq;    // final byte is '='
        logic end_apos;  // final byte is an apostrophe
    } tok_flags_t;

    localparam int TOK_FLAGS_W = $bits(tok_flags_t);

    localparam logic [1:0] FT_CODE = 2'd1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Length limits and layout positions
    localparam int MIN_LEN       = 2;
    localparam int MAX_LEN_PROSE = 24;
    localparam int MAX_LEN_CODE  = 40;
    localparam int UUID_LEN      = 36;
    localparam int UUID_DASH0    = 8;
    localparam int UUID_DASH1    = 13;
    localparam int UUID_DASH2    = 18;
    localparam int UUID_DASH3    = 23;
    localparam int PFX_MIN_LEN   = 3;
    localparam int HEX_MIN_LEN   = 6;
    localparam int CAPS_MAX_LEN  = 6;
    localparam int B64_RULE_LEN  = 16;
    localparam int VOWEL_MIN_LEN = 6;

    // Ratio thresholds in percent
    localparam int PCT_FULL  = 100;
    localparam int DIGIT_PCT = 51;
    localparam int B64_PCT   = 95;
    localparam int VOWEL_PCT = 15;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LA) && (c <= CH_LZ);
    endfunction

    function automatic logic is_hexc(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

endpackage

// ===== rtl/tjf_front.sv =====
// Front end: takes token bytes, keeps running counts and pattern flags.
module tjf_front import tjf_pkg::*; #(
    parameter int COUNT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            file_type,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  last,
    input  logic                  q_full,
    output logic                  q_push,
    output tok_flags_t            q_flags,
    output logic [COUNT_BITS-1:0] q_len,
    output logic [COUNT_BITS-1:0] q_digits,
    output logic [COUNT_BITS-1:0] q_vowels,
    output logic [COUNT_BITS-1:0] q_b64
);

    localparam logic [COUNT_BITS-1:0] CMAX    = '1;
    localparam logic [COUNT_BITS-1:0] IDX_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] IDX_D0  = COUNT_BITS'(UUID_DASH0);
    localparam logic [COUNT_BITS-1:0] IDX_D1  = COUNT_BITS'(UUID_DASH1);
    localparam logic [COUNT_BITS-1:0] IDX_D2  = COUNT_BITS'(UUID_DASH2);
    localparam logic [COUNT_BITS-1:0] IDX_D3  = COUNT_BITS'(UUID_DASH3);
    localparam logic [COUNT_BITS-1:0] IDX_UL  = COUNT_BITS'(UUID_LEN);

    logic [COUNT_BITS-1:0] len_reg, len_next;
    logic [COUNT_BITS-1:0] dig_reg, dig_next;
    logic [COUNT_BITS-1:0] vow_reg, vow_next;
    logic [COUNT_BITS-1:0] b64_reg, b64_next;
    logic [15:0]           prev_reg, prev_next;
    logic                  hex_reg, hex_next;
    logic                  uuid_reg, uuid_next;
    logic                  caps_reg, caps_next;
    logic                  bad_reg, bad_next;
    logic                  pfx_reg, pfx_next;

    logic [7:0] p1, p2, lc;
    logic       take, is_vowel, is_b64, uuid_dash, uuid_clr, caps_ok, bad_set, pfx_set;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign q_push   = take && last;

    assign p1 = prev_reg[7:0];
    assign p2 = prev_reg[15:8];
    assign lc = ch | CASE_BIT;

    always_comb
    begin
        is_vowel  = (lc == CH_LA) || (lc == CH_LE) || (lc == CH_LI) ||
                    (lc == CH_LO) || (lc == CH_LU);
        is_b64    = is_upper(ch) || is_lower(ch) || is_digit(ch) ||
                    (ch == CH_PLUS) || (ch == CH_SLASH) || (ch == CH_EQ);
        uuid_dash = (len_reg == IDX_D0) || (len_reg == IDX_D1) ||
                    (len_reg == IDX_D2) || (len_reg == IDX_D3);
        uuid_clr  = uuid_dash ? (ch != CH_DASH)
                              : ((len_reg >= IDX_UL) || !is_hexc(ch));
        caps_ok   = (ch == CH_UNDER) || is_upper(ch) || is_digit(ch);
        bad_set   = (ch == CH_EQ) || (ch == CH_SLASH) || (ch == CH_BSL);
        pfx_set   = (len_reg == IDX_ONE) && (p1 == CH_ZERO) &&
                    ((ch == CH_LX) || (ch == CH_UX));

        len_next  = (len_reg == CMAX) ? len_reg : len_reg + 1'b1;
        dig_next  = (is_digit(ch) && (dig_reg != CMAX)) ? dig_reg + 1'b1 : dig_reg;
        vow_next  = (is_vowel && (vow_reg != CMAX)) ? vow_reg + 1'b1 : vow_reg;
        b64_next  = (is_b64 && (b64_reg != CMAX)) ? b64_reg + 1'b1 : b64_reg;
        prev_next = {p1, ch};
        hex_next  = hex_reg && is_hexc(ch);
        uuid_next = uuid_reg && !uuid_clr;
        caps_next = caps_reg && caps_ok;
        // "://" is covered by the slash test, kept for clarity of intent
        bad_next  = bad_reg || bad_set ||
                    ((ch == CH_SLASH) && (p1 == CH_SLASH) && (p2 == CH_COLON));
        pfx_next  = pfx_reg || pfx_set;
    end

    always_comb
    begin
        q_len            = len_next;
        q_digits         = dig_next;
        q_vowels         = vow_next;
        q_b64            = b64_next;
        q_flags.code     = (file_type == FT_CODE);
        q_flags.hex      = hex_next;
        q_flags.uuid     = uuid_next;
        q_flags.caps     = caps_next;
        q_flags.bad      = bad_next;
        q_flags.pfx_hex  = pfx_next;
        q_flags.end_eq   = (ch == CH_EQ);
        q_flags.end_apos = (ch == CH_APOS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            dig_reg  <= '0;
            vow_reg  <= '0;
            b64_reg  <= '0;
            prev_reg <= '0;
            hex_reg  <= 1'b1;
            uuid_reg <= 1'b1;
            caps_reg <= 1'b1;
            bad_reg  <= 1'b0;
            pfx_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                len_reg  <= '0;
                dig_reg  <= '0;
                vow_reg  <= '0;
                b64_reg  <= '0;
                prev_reg <= '0;
                hex_reg  <= 1'b1;
                uuid_reg <= 1'b1;
                caps_reg <= 1'b1;
                bad_reg  <= 1'b0;
                pfx_reg  <= 1'b0;
            end
            else
            begin
                len_reg  <= len_next;
                dig_reg  <= dig_next;
                vow_reg  <= vow_next;
                b64_reg  <= b64_next;
                prev_reg <= prev_next;
                hex_reg  <= hex_next;
                uuid_reg <= uuid_next;
                caps_reg <= caps_next;
                bad_reg  <= bad_next;
                pfx_reg  <= pfx_next;
            end
        end
    end

endmodule

// ===== rtl/tjf_queue.sv =====
// Two-entry registered queue of finished token summaries.
module tjf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [1:0]       cnt_reg, cnt_next;
    logic [WIDTH-1:0] head_reg, head_next;
    logic [WIDTH-1:0] spare_reg, spare_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = head_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        unique case ({push, pop})
            2'b10:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                    head_next = push_data;
                else
                    spare_next = push_data;
            end
            2'b01:
            begin
                cnt_next  = cnt_reg - 2'd1;
                head_next = spare_reg;
            end
            2'b11:
            begin
                // only reachable with one entry held
                if (cnt_reg == 2'd1)
                    head_next = push_data;
                else
                begin
                    head_next  = spare_reg;
                    spare_next = push_data;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

endmodule

// ===== rtl/tjf_back.sv =====
// Decision stage: applies the rule table to a token summary, holds the result.
module tjf_back import tjf_pkg::*; #(
    parameter int COUNT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  tok_flags_t            q_flags,
    input  logic [COUNT_BITS-1:0] q_len,
    input  logic [COUNT_BITS-1:0] q_digits,
    input  logic [COUNT_BITS-1:0] q_vowels,
    input  logic [COUNT_BITS-1:0] q_b64,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accept
);

    localparam int PW = COUNT_BITS + 7;

    localparam logic [COUNT_BITS-1:0] L_MIN   = COUNT_BITS'(MIN_LEN);
    localparam logic [COUNT_BITS-1:0] L_PROSE = COUNT_BITS'(MAX_LEN_PROSE);
    localparam logic [COUNT_BITS-1:0] L_CODE  = COUNT_BITS'(MAX_LEN_CODE);
    localparam logic [COUNT_BITS-1:0] L_UUID  = COUNT_BITS'(UUID_LEN);
    localparam logic [COUNT_BITS-1:0] L_PFX   = COUNT_BITS'(PFX_MIN_LEN);
    localparam logic [COUNT_BITS-1:0] L_HEX   = COUNT_BITS'(HEX_MIN_LEN);
    localparam logic [COUNT_BITS-1:0] L_CAPS  = COUNT_BITS'(CAPS_MAX_LEN);
    localparam logic [COUNT_BITS-1:0] L_B64   = COUNT_BITS'(B64_RULE_LEN);
    localparam logic [COUNT_BITS-1:0] L_VOW   = COUNT_BITS'(VOWEL_MIN_LEN);

    logic                  out_valid_reg, out_valid_next;
    logic                  accept_reg, accept_next;
    logic [COUNT_BITS-1:0] max_len;
    logic [PW-1:0]         dig_pct, len_dig, b64_pct, len_b64, vow_pct, len_vow;
    logic                  reject, prose_reject;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        max_len = q_flags.code ? L_CODE : L_PROSE;
        // ratios by cross-multiplication against constant percentages
        dig_pct = PW'(q_digits) * PW'(PCT_FULL);
        len_dig = PW'(q_len) * PW'(DIGIT_PCT);
        b64_pct = PW'(q_b64) * PW'(PCT_FULL);
        len_b64 = PW'(q_len) * PW'(B64_PCT);
        vow_pct = PW'(q_vowels) * PW'(PCT_FULL);
        len_vow = PW'(q_len) * PW'(VOWEL_PCT);

        prose_reject = (dig_pct >= len_dig) ||
                       (q_flags.caps && (q_len > L_CAPS)) ||
                       ((q_len >= L_B64) && q_flags.end_eq && (b64_pct >= len_b64)) ||
                       (q_vowels == '0) ||
                       ((q_len >= L_VOW) && (vow_pct < len_vow));

        reject = (q_len < L_MIN) || (q_len > max_len) ||
                 (q_digits == q_len) ||
                 (q_flags.uuid && (q_len == L_UUID)) ||
                 q_flags.bad ||
                 (q_flags.pfx_hex && (q_len >= L_PFX)) ||
                 (q_flags.hex && (q_len >= L_HEX)) ||
                 (!q_flags.code && prose_reject) ||
                 q_flags.end_apos;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        accept_next    = accept_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            accept_next    = !reject;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        accept_reg <= accept_next;
    end

    assign out_valid = out_valid_reg;
    assign accept    = accept_reg;

endmodule

// ===== rtl/token_junk_filter.sv =====
// Top level of the token junk filter: rule-set register, front end, queue, decision stage.
//
// Input channel (in_valid/in_ready, ch, last) carries one byte of a token per
// transaction; last marks the final byte. Every token yields exactly one result
// transaction on the output channel (out_valid/out_ready, accept): 1 keeps the
// token, 0 rejects it. Bytes that are not final give no result.
// file_type selects the rule set (1 for code, any other value prose); it is written on
// a cycle with cfg_we high and should only change between tokens.
// Throughput: one byte per cycle while in_ready is high. The result of a token
// passes through the summary queue register and then the decision output
// register after its final byte is taken.
// The front end updates its counters and flags for each byte taken and
// hands a summary of each finished token to a two-entry queue; the decision
// stage drains it into the output register. When the receiver stalls, up to
// three results wait (two queued, one at the output); while the queue is full
// in_ready drops. After reset the counters are clear, no result is pending and
// the prose rule set is selected.
module token_junk_filter import tjf_pkg::*; #(
    parameter int COUNT_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] file_type,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       accept
);

    localparam int QW = TOK_FLAGS_W + 4 * COUNT_BITS;

    logic [1:0]            file_type_reg;
    logic                  q_full, q_push, q_pop, q_valid;
    tok_flags_t            f_flags, b_flags;
    logic [COUNT_BITS-1:0] f_len, f_dig, f_vow, f_b64;
    logic [COUNT_BITS-1:0] b_len, b_dig, b_vow, b_b64;
    logic [QW-1:0]         q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_type_reg <= 2'd0;
        else if (cfg_we)
            file_type_reg <= file_type;
    end

    tjf_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .file_type (file_type_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_flags   (f_flags),
        .q_len     (f_len),
        .q_digits  (f_dig),
        .q_vowels  (f_vow),
        .q_b64     (f_b64)
    );

    assign q_in = {f_flags, f_len, f_dig, f_vow, f_b64};

    tjf_queue #(.WIDTH(QW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    assign {b_flags, b_len, b_dig, b_vow, b_b64} = q_out;

    tjf_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_flags   (b_flags),
        .q_len     (b_len),
        .q_digits  (b_dig),
        .q_vowels  (b_vow),
        .q_b64     (b_b64),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accept    (accept)
    );

endmodule

// ===== rtl/tjf_checker.sv =====
// Port-level checker for the token junk filter, bound to the top level.
module tjf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic last,
    input logic out_valid,
    input logic out_ready,
    input logic accept
);

    // tokens taken whose result has not yet been delivered
    logic [1:0] pend_reg, pend_next;
    logic       tok_in, tok_out;

    assign tok_in  = in_valid && in_ready && last;
    assign tok_out = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, tok_in} - {1'b0, tok_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accept))
        else $error("result changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result shown with no token outstanding");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd3 |-> !in_ready)
        else $error("input taken with every result slot occupied");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd0 && !out_valid |=> out_valid)
        else $error("outstanding token gave no result");

endmodule

bind token_junk_filter tjf_checker u_tjf_checker (.*);
